// ===== design/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACK_TIMEOUT = 3'd0;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   localparam logic [2:0] CMD_START = 3'd0;
   localparam logic [2:0] CMD_STOP  = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_WAIT  = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   localparam logic MODE_TICK    = 1'b0;
   localparam logic MODE_COMMAND = 1'b1;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_1    = 6'b000010,
      PH_2    = 6'b000100,
      PH_3    = 6'b001000,
      PH_4    = 6'b010000,
      PH_5    = 6'b100000
   } phase_type;

   typedef struct packed {
      logic       mode;
      logic [2:0] command;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic       ack_failed;
      logic [7:0] rx_byte;
   } rsp_type;

   typedef struct packed {
      logic [2:0] cmd;
      phase_type  phase;
      logic [3:0] bit_count;
      logic [7:0] shift_reg;
      logic [7:0] wait_count;
      logic       ack_choice;
      logic       scl;
      logic       sda;
      logic       drv;
      logic       fail_flag;
      logic [7:0] rx_hold;
   } engine_state_type;

   localparam engine_state_type ENGINE_RESET = '{
      cmd:        CMD_START,
      phase:      PH_IDLE,
      bit_count:  4'd0,
      shift_reg:  8'd0,
      wait_count: 8'd0,
      ack_choice: 1'b0,
      scl:        1'b1,
      sda:        1'b1,
      drv:        1'b0,
      fail_flag:  1'b0,
      rx_hold:    8'd0
   };

endpackage

// ===== design/i2cm_step.sv =====
// Next-state and result logic of the I2C master for one request.
module i2cm_step
   import i2cm_pkg::*;
(
   input  engine_state_type state_cur,
   input  req_type          req,
   input  logic [7:0]       ack_timeout,
   output engine_state_type state_nxt,
   output rsp_type          rsp
);

   logic       done;
   logic [3:0] bit_cnt_inc;
   logic [7:0] wait_cnt_inc;
   logic [7:0] rx_shift;

   assign bit_cnt_inc  = state_cur.bit_count + 4'd1;
   assign wait_cnt_inc = state_cur.wait_count + 8'd1;
   assign rx_shift     = {state_cur.shift_reg[6:0], req.sda_in};

   always_comb begin
      state_nxt = state_cur;
      done = 1'b0;
      if (req.mode == MODE_COMMAND) begin
         if (state_cur.phase == PH_IDLE && (req.command inside {[CMD_START:CMD_READ]})) begin
            state_nxt.cmd        = req.command;
            state_nxt.phase      = PH_1;
            state_nxt.bit_count  = 4'd0;
            state_nxt.wait_count = 8'd0;
            state_nxt.fail_flag  = 1'b0;
            case (req.command)
               CMD_START: begin
                  state_nxt.drv = 1'b1;
                  state_nxt.sda = 1'b1;
                  state_nxt.scl = 1'b1;
               end
               CMD_STOP: begin
                  state_nxt.drv = 1'b1;
                  state_nxt.scl = 1'b0;
                  state_nxt.sda = 1'b0;
               end
               CMD_WRITE: begin
                  state_nxt.drv       = 1'b1;
                  state_nxt.scl       = 1'b0;
                  state_nxt.sda       = req.tx_byte[7];
                  state_nxt.shift_reg = {req.tx_byte[6:0], 1'b0};
                  state_nxt.bit_count = 4'd1;
               end
               CMD_WAIT: begin
                  state_nxt.drv = 1'b0;
                  state_nxt.sda = 1'b1;
                  state_nxt.scl = 1'b0;
               end
               default: begin
                  state_nxt.drv        = 1'b0;
                  state_nxt.scl        = 1'b0;
                  state_nxt.shift_reg  = 8'd0;
                  state_nxt.ack_choice = req.send_ack;
               end
            endcase
         end
      end else if (state_cur.phase != PH_IDLE) begin
         case (state_cur.cmd)
            CMD_START: begin
               if (state_cur.phase == PH_1) begin
                  state_nxt.sda   = 1'b0;
                  state_nxt.phase = PH_2;
               end else begin
                  state_nxt.scl = 1'b0;
                  done = 1'b1;
               end
            end
            CMD_STOP: begin
               if (state_cur.phase == PH_1) begin
                  state_nxt.scl   = 1'b1;
                  state_nxt.phase = PH_2;
               end else if (state_cur.phase == PH_2) begin
                  state_nxt.sda   = 1'b1;
                  state_nxt.phase = PH_3;
               end else begin
                  done = 1'b1;
               end
            end
            CMD_WRITE: begin
               if (state_cur.phase == PH_1) begin
                  state_nxt.scl   = 1'b1;
                  state_nxt.phase = PH_2;
               end else if (state_cur.phase == PH_2) begin
                  state_nxt.scl   = 1'b0;
                  state_nxt.phase = PH_3;
               end else if (state_cur.bit_count < BITS_PER_BYTE) begin
                  state_nxt.sda       = state_cur.shift_reg[7];
                  state_nxt.shift_reg = {state_cur.shift_reg[6:0], 1'b0};
                  state_nxt.bit_count = bit_cnt_inc;
                  state_nxt.phase     = PH_1;
               end else begin
                  done = 1'b1;
               end
            end
            CMD_WAIT: begin
               if (state_cur.phase == PH_1) begin
                  state_nxt.scl   = 1'b1;
                  state_nxt.phase = PH_2;
               end else if (state_cur.phase == PH_2) begin
                  if (!req.sda_in) begin
                     state_nxt.scl = 1'b0;
                     done = 1'b1;
                  end else begin
                     state_nxt.wait_count = wait_cnt_inc;
                     // Timed out: pull both lines low and run a stop sequence.
                     if (wait_cnt_inc > ack_timeout) begin
                        state_nxt.drv   = 1'b1;
                        state_nxt.scl   = 1'b0;
                        state_nxt.sda   = 1'b0;
                        state_nxt.phase = PH_3;
                     end
                  end
               end else if (state_cur.phase == PH_3) begin
                  state_nxt.scl   = 1'b1;
                  state_nxt.phase = PH_4;
               end else if (state_cur.phase == PH_4) begin
                  state_nxt.sda   = 1'b1;
                  state_nxt.phase = PH_5;
               end else begin
                  state_nxt.fail_flag = 1'b1;
                  done = 1'b1;
               end
            end
            default: begin
               if (state_cur.phase == PH_1) begin
                  state_nxt.scl   = 1'b1;
                  state_nxt.phase = PH_2;
               end else if (state_cur.phase == PH_2) begin
                  state_nxt.shift_reg = rx_shift;
                  state_nxt.bit_count = bit_cnt_inc;
                  state_nxt.scl       = 1'b0;
                  if (bit_cnt_inc < BITS_PER_BYTE) begin
                     state_nxt.phase = PH_1;
                  end else begin
                     // Byte complete: drive ACK (low) or NACK (high).
                     state_nxt.rx_hold = rx_shift;
                     state_nxt.drv     = 1'b1;
                     state_nxt.sda     = ~state_cur.ack_choice;
                     state_nxt.phase   = PH_3;
                  end
               end else if (state_cur.phase == PH_3) begin
                  state_nxt.scl   = 1'b1;
                  state_nxt.phase = PH_4;
               end else begin
                  state_nxt.scl = 1'b0;
                  done = 1'b1;
               end
            end
         endcase
         if (done) begin
            state_nxt.phase = PH_IDLE;
         end
      end
   end

   always_comb begin
      rsp.scl_level  = state_nxt.scl;
      rsp.sda_level  = state_nxt.sda;
      rsp.sda_drive  = state_nxt.drv;
      rsp.busy_res   = (state_nxt.phase != PH_IDLE);
      rsp.done_res   = done;
      rsp.ack_failed = state_nxt.fail_flag;
      rsp.rx_byte    = state_nxt.rx_hold;
   end

endmodule

// ===== design/i2c_master_bit_engine.sv =====
// I2C master bit engine: one request per cycle unless stalled, each giving one result with the bus lines.
// Every request (a command or one tick of bus time) is captured in an input register,
// then stepped through the engine state and written to the result register; the block
// sustains one request per clock while results are not stalled, and the input register
// lets one more request in while a result is stalled.
// Commands are taken only while idle; ack_timeout at byte address 0 sets how many
// high SDA ticks an ack wait tolerates before it issues a stop and flags the failure.
module i2c_master_bit_engine
   import i2cm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic             in_valid_ff, in_valid_in;
   req_type          req_ff, req_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   engine_state_type state_ff, state_in, state_step;
   rsp_type          rsp_step;
   logic [7:0]       timeout_ff, timeout_in;
   logic             advance;
   logic             req_take;
   logic             csr_write;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   i2cm_step u_step (
      .state_cur   (state_ff),
      .req         (req_ff),
      .ack_timeout (timeout_ff),
      .state_nxt   (state_step),
      .rsp         (rsp_step)
   );

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      req_in       = req_take ? req_data : req_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_in       = advance ? rsp_step : rsp_ff;
      state_in     = advance ? state_step : state_ff;
   end

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign timeout_in = (csr_write && csr_paddr == CSR_ACK_TIMEOUT) ? csr_pwdata[7:0]
                                                                    : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ENGINE_RESET;
         timeout_ff   <= ACK_TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ACK_TIMEOUT)
                       ? {{(CSR_DATA_W-8){1'b0}}, timeout_ff} : '0;

`ifndef SYNTH
   // A finished command never reports itself as still running.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.done_res && rsp_data.busy_res))
      else $error("result shows done and busy together");

   // A failed ack wait ends after the stop: both lines high and SDA driven.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_res && rsp_data.ack_failed)
      |-> (rsp_data.scl_level && rsp_data.sda_level && rsp_data.sda_drive))
      else $error("ack failure reported without a completed stop");

   // A held request is not dropped while the result side is stalled.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && rsp_stall) |=> in_valid_ff)
      else $error("pending request lost during result stall");

   // The engine always sits in exactly one phase.
   assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.phase))
      else $error("engine phase is not one-hot");
`endif

endmodule

// ===== sim/tb_i2c_master_bit_engine.sv =====
// Self-checking testbench for the I2C master bit engine, with its own predictor of the bus lines.
module tb_i2c_master_bit_engine;
   timeunit 1ns;
   timeprecision 1ps;
   import i2cm_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int RANDOM_PHASE_REQUESTS = 75;
   localparam int HOLD_STRETCH = 60;
   localparam logic [CSR_ADDR_W-1:0] UNUSED_CSR_ADDR = 3'd4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Predicted engine state and the ack timeout it runs with.
   engine_state_type eng = ENGINE_RESET;
   logic [7:0] ack_limit = ACK_TIMEOUT_RESET;
   rsp_type expected_lines[$];

   int error_count = 0;
   int requests_sent = 0;
   int results_seen = 0;
   int timeouts_seen = 0;
   int cycle_count = 0;
   int hold_cycles = 0;
   bit no_idle = 1'b0;

   i2c_master_bit_engine dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void shift_out_bit();
      eng.sda = eng.shift_reg[7];
      eng.shift_reg = {eng.shift_reg[6:0], 1'b0};
      eng.bit_count = eng.bit_count + 4'd1;
   endfunction

   // One bus delay of the running command; returns 1 when the command completes.
   function automatic bit advance_tick(input logic sda_in);
      case (eng.cmd)
         CMD_START: begin
            if (eng.phase == PH_1) begin
               eng.sda = 1'b0;
               eng.phase = PH_2;
               return 1'b0;
            end
            eng.scl = 1'b0;
            return 1'b1;
         end
         CMD_STOP: begin
            if (eng.phase == PH_1) begin
               eng.scl = 1'b1;
               eng.phase = PH_2;
               return 1'b0;
            end
            if (eng.phase == PH_2) begin
               eng.sda = 1'b1;
               eng.phase = PH_3;
               return 1'b0;
            end
            return 1'b1;
         end
         CMD_WRITE: begin
            if (eng.phase == PH_1) begin
               eng.scl = 1'b1;
               eng.phase = PH_2;
               return 1'b0;
            end
            if (eng.phase == PH_2) begin
               eng.scl = 1'b0;
               eng.phase = PH_3;
               return 1'b0;
            end
            if (eng.bit_count < BITS_PER_BYTE) begin
               shift_out_bit();
               eng.phase = PH_1;
               return 1'b0;
            end
            return 1'b1;
         end
         CMD_WAIT: begin
            if (eng.phase == PH_1) begin
               eng.scl = 1'b1;
               eng.phase = PH_2;
               return 1'b0;
            end
            if (eng.phase == PH_2) begin
               if (!sda_in) begin
                  eng.scl = 1'b0;
                  return 1'b1;
               end
               eng.wait_count = eng.wait_count + 8'd1;
               // Past the limit the engine takes the bus back and runs a stop.
               if (eng.wait_count > ack_limit) begin
                  eng.drv = 1'b1;
                  eng.scl = 1'b0;
                  eng.sda = 1'b0;
                  eng.phase = PH_3;
               end
               return 1'b0;
            end
            if (eng.phase == PH_3) begin
               eng.scl = 1'b1;
               eng.phase = PH_4;
               return 1'b0;
            end
            if (eng.phase == PH_4) begin
               eng.sda = 1'b1;
               eng.phase = PH_5;
               return 1'b0;
            end
            eng.fail_flag = 1'b1;
            return 1'b1;
         end
         default: begin
            if (eng.phase == PH_1) begin
               eng.scl = 1'b1;
               eng.phase = PH_2;
               return 1'b0;
            end
            if (eng.phase == PH_2) begin
               eng.shift_reg = {eng.shift_reg[6:0], sda_in};
               eng.bit_count = eng.bit_count + 4'd1;
               eng.scl = 1'b0;
               if (eng.bit_count < BITS_PER_BYTE) begin
                  eng.phase = PH_1;
                  return 1'b0;
               end
               eng.rx_hold = eng.shift_reg;
               eng.drv = 1'b1;
               eng.sda = (eng.ack_choice == 1'b0);
               eng.phase = PH_3;
               return 1'b0;
            end
            if (eng.phase == PH_3) begin
               eng.scl = 1'b1;
               eng.phase = PH_4;
               return 1'b0;
            end
            eng.scl = 1'b0;
            return 1'b1;
         end
      endcase
   endfunction

   function automatic rsp_type bus_step(input req_type r);
      rsp_type lines;
      bit finished;
      finished = 1'b0;
      if (r.mode == MODE_COMMAND) begin
         // Commands are only taken while idle, and codes above read are dropped.
         if (eng.phase == PH_IDLE && r.command <= CMD_READ) begin
            eng.cmd = r.command;
            eng.phase = PH_1;
            eng.bit_count = 4'd0;
            eng.wait_count = 8'd0;
            eng.fail_flag = 1'b0;
            case (r.command)
               CMD_START: begin
                  eng.drv = 1'b1;
                  eng.sda = 1'b1;
                  eng.scl = 1'b1;
               end
               CMD_STOP: begin
                  eng.drv = 1'b1;
                  eng.scl = 1'b0;
                  eng.sda = 1'b0;
               end
               CMD_WRITE: begin
                  eng.drv = 1'b1;
                  eng.scl = 1'b0;
                  eng.shift_reg = r.tx_byte;
                  shift_out_bit();
               end
               CMD_WAIT: begin
                  eng.drv = 1'b0;
                  eng.sda = 1'b1;
                  eng.scl = 1'b0;
               end
               default: begin
                  eng.drv = 1'b0;
                  eng.scl = 1'b0;
                  eng.shift_reg = 8'd0;
                  eng.ack_choice = r.send_ack;
               end
            endcase
         end
      end else if (eng.phase != PH_IDLE) begin
         finished = advance_tick(r.sda_in);
         if (finished)
            eng.phase = PH_IDLE;
      end
      lines.scl_level = eng.scl;
      lines.sda_level = eng.sda;
      lines.sda_drive = eng.drv;
      lines.busy_res = (eng.phase != PH_IDLE);
      lines.done_res = finished;
      lines.ack_failed = eng.fail_flag;
      lines.rx_byte = eng.rx_hold;
      return lines;
   endfunction

   // ---------------------------------------------------------------- request side

   task automatic send_req(input req_type r);
      int gap;
      rsp_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = bus_step(r);
      expected_lines.push_back(predicted);
      requests_sent++;
      if (predicted.done_res && predicted.ack_failed)
         timeouts_seen++;
   endtask

   task automatic send_cmd(input logic [2:0] code, input logic [7:0] tx, input logic ack);
      req_type r;
      r.mode = MODE_COMMAND;
      r.command = code;
      r.tx_byte = tx;
      r.send_ack = ack;
      r.sda_in = 1'($urandom);
      send_req(r);
   endtask

   // Fields a tick does not use carry random values.
   task automatic send_tick(input logic sda);
      req_type r;
      r.mode = MODE_TICK;
      r.command = 3'($urandom);
      r.tx_byte = 8'($urandom);
      r.send_ack = 1'($urandom);
      r.sda_in = sda;
      send_req(r);
   endtask

   task automatic finish_command();
      while (eng.phase != PH_IDLE) send_tick(1'b0);
   endtask

   // Always waits on the clock before polling the queue, so a following request never meets the lowering.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_lines.size() != 0) @(posedge clock);
   endtask

   task automatic settle_block();
      wait_for_results();
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- register port

   task automatic csr_access(input bit wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic verify_ack_timeout();
      logic [CSR_DATA_W-1:0] readback;
      csr_access(1'b0, CSR_ACK_TIMEOUT, '0, readback);
      if (readback !== {24'd0, ack_limit}) begin
         $error("ack_timeout readback: expected %0h, actual %0h", {24'd0, ack_limit}, readback);
         error_count++;
      end
   endtask

   task automatic set_ack_timeout(input logic [7:0] value);
      logic [CSR_DATA_W-1:0] unused;
      settle_block();
      csr_access(1'b1, CSR_ACK_TIMEOUT, {24'd0, value}, unused);
      ack_limit = value;
      verify_ack_timeout();
   endtask

   // ---------------------------------------------------------------- result side

   task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (expected_lines.size() == 0) begin
         $error("result with no request outstanding: %0h", got);
         error_count++;
      end else begin
         want = expected_lines.pop_front();
         cmp_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
         cmp_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
         cmp_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
         cmp_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
         cmp_field("done_res", 8'(want.done_res), 8'(got.done_res));
         cmp_field("ack_failed", 8'(want.ack_failed), 8'(got.ack_failed));
         cmp_field("rx_byte", want.rx_byte, got.rx_byte);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_result(rsp_data);
   end

   initial begin : result_sink
      int wait_cycles;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         wait_cycles = no_idle ? 0 : $urandom_range(0, 4);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL i2c_master_bit_engine");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   task automatic test_reset_values();
      verify_ack_timeout();
      send_tick(1'($urandom));
   endtask

   task automatic test_start_and_stop();
      send_cmd(CMD_START, 8'($urandom), 1'($urandom));
      finish_command();
      send_cmd(CMD_STOP, 8'($urandom), 1'($urandom));
      finish_command();
      send_tick(1'b1);
   endtask

   task automatic test_write_byte();
      send_cmd(CMD_WRITE, 8'hFF, 1'b0);
      repeat (5) send_tick(1'b1);
      // A command in the middle of a byte must not disturb it.
      send_cmd(CMD_READ, 8'h00, 1'b1);
      finish_command();
      send_cmd(CMD_WRITE, 8'h00, 1'b1);
      finish_command();
   endtask

   task automatic test_ack_wait();
      logic [CSR_DATA_W-1:0] unused;
      // With the largest limit the wait can only end on a low SDA.
      set_ack_timeout(8'd255);
      send_cmd(CMD_WAIT, 8'($urandom), 1'($urandom));
      repeat (12) send_tick(1'b1);
      send_tick(1'b0);
      // A zero limit fails on the first high sample and runs the stop.
      set_ack_timeout(8'd0);
      send_cmd(CMD_WAIT, 8'($urandom), 1'($urandom));
      send_tick(1'b1);
      send_tick(1'b1);
      finish_command();
      // Writes to an address past the only register are dropped.
      settle_block();
      csr_access(1'b1, UNUSED_CSR_ADDR, 32'hFFFF_FF07, unused);
      verify_ack_timeout();
      send_cmd(CMD_WAIT, 8'($urandom), 1'($urandom));
      send_tick(1'b1);
      send_tick(1'b1);
      finish_command();
      // The next accepted command clears the failure flag.
      send_cmd(CMD_START, 8'($urandom), 1'($urandom));
      finish_command();
   endtask

   task automatic test_read_byte();
      logic [7:0] pattern;
      set_ack_timeout(ACK_TIMEOUT_RESET);
      for (int k = 0; k < 2; k++) begin
         pattern = (k == 0) ? 8'hA5 : 8'h3C;
         send_cmd(CMD_READ, 8'($urandom), (k == 0));
         for (int i = 7; i >= 0; i--) begin
            send_tick(1'($urandom));
            send_tick(pattern[i]);
         end
         finish_command();
      end
   endtask

   task automatic test_ignored_requests();
      send_cmd(3'd5, 8'($urandom), 1'($urandom));
      send_cmd(3'd6, 8'($urandom), 1'($urandom));
      send_cmd(3'd7, 8'($urandom), 1'($urandom));
      send_tick(1'b0);
      send_cmd(CMD_STOP, 8'($urandom), 1'($urandom));
      send_cmd(CMD_START, 8'($urandom), 1'($urandom));
      send_tick(1'b1);
      send_cmd(CMD_WRITE, 8'($urandom), 1'($urandom));
      finish_command();
   endtask

   task automatic test_backpressure();
      settle_block();
      // The sink holds off while requests keep coming, so the block fills and stalls.
      no_idle = 1'b1;
      hold_cycles = HOLD_STRETCH;
      send_cmd(CMD_WRITE, 8'($urandom), 1'($urandom));
      finish_command();
      no_idle = 1'b0;
      wait_for_results();
   endtask

   task automatic run_random_phase(input int n_requests);
      int useful;
      int roll;
      bit paused;
      useful = 0;
      paused = 1'b0;
      while (useful < n_requests) begin
         roll = $urandom_range(0, 19);
         if (eng.phase == PH_IDLE) begin
            if (roll == 0) begin
               send_cmd(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom));
            end else if (roll == 1) begin
               send_tick(1'($urandom));
            end else begin
               send_cmd(3'($urandom_range(0, 4)), 8'($urandom), 1'($urandom));
               useful++;
            end
         end else begin
            if (roll == 0) begin
               send_cmd(3'($urandom), 8'($urandom), 1'($urandom));
            end else begin
               // Mostly high SDA during an ack wait, so short limits run out.
               if (eng.cmd == CMD_WAIT)
                  send_tick($urandom_range(0, 3) != 0);
               else
                  send_tick(1'($urandom));
               useful++;
            end
         end
         if (!paused && useful >= n_requests / 2) begin
            paused = 1'b1;
            wait_for_results();
         end
      end
      finish_command();
   endtask

   task automatic test_random_traffic();
      set_ack_timeout(8'd2);
      run_random_phase(RANDOM_PHASE_REQUESTS);
      set_ack_timeout(8'd0);
      run_random_phase(RANDOM_PHASE_REQUESTS);
      set_ack_timeout(8'd255);
      no_idle = 1'b1;
      run_random_phase(RANDOM_PHASE_REQUESTS);
      no_idle = 1'b0;
      set_ack_timeout(8'($urandom_range(1, 12)));
      run_random_phase(RANDOM_PHASE_REQUESTS);
      set_ack_timeout(ACK_TIMEOUT_RESET);
      run_random_phase(RANDOM_PHASE_REQUESTS);
   endtask

   initial begin : main_sequence
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_start_and_stop();
      test_write_byte();
      test_ack_wait();
      test_read_byte();
      test_ignored_requests();
      test_backpressure();
      test_random_traffic();
      wait_for_results();
      repeat (8) @(posedge clock);
      $display("Ran %0d requests and checked %0d results, %0d of them ack waits that timed out.",
               requests_sent, results_seen, timeouts_seen);
      $display("Ack limits 0, 2, 255, the reset value and a random one; a long sink stall included.");
      if (error_count == 0)
         $display("PASS i2c_master_bit_engine");
      else
         $display("FAIL i2c_master_bit_engine");
      $finish;
   end

endmodule
